// ===== design/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by skt_ctrl, skt_datapath and sorted_key_table_top; depends on nothing.
package skt_pkg;

  localparam int KEY_W                 = 32;
  localparam int PAY_PORT_W            = 32;
  localparam int CAPACITY_DEFAULT      = 16;
  localparam int PAYLOAD_WIDTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the incoming request
    logic exec;       // run the latched operation on the cell chain
    logic dump_step;  // emit cell 0 and rotate the chain by one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic empty;
    logic dump_last;
  } stat_t;

endpackage

// ===== design/skt_ctrl.sv =====
// Controller state machine for the sorted key table.
// Depends on skt_pkg for the command and status structs.
module skt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           request_valid,
  output logic           request_ready,
  output logic           result_valid,
  input  logic           result_ready,
  input  skt_pkg::stat_t stat,
  output skt_pkg::cmd_t  cmd
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;
  logic   out_set;
  logic   dump_go;

  // The output register may be refilled in the cycle its result leaves.
  assign out_free      = !out_valid || result_ready;
  assign request_ready = (state == S_IDLE);
  assign result_valid  = out_valid;
  assign dump_go       = (stat.op == OP_DUMP) && !stat.empty;

  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    cmd.dump_step = 1'b0;
    case (state)
      S_IDLE: begin
        if (request_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = dump_go ? S_DUMP : S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.dump_step = 1'b1;
          if (stat.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_set = (cmd.exec && !dump_go) || cmd.dump_step;

  always_comb begin
    out_valid_next = out_valid;
    if (out_set) begin
      out_valid_next = 1'b1;
    end else if (result_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/skt_datapath.sv =====
// Datapath of the sorted key table: request registers, the sorted cell chain,
// the entry counter and the result register. Depends on skt_pkg.
module skt_datapath #(
  parameter int CAPACITY      = skt_pkg::CAPACITY_DEFAULT,
  parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  skt_pkg::cmd_t                        cmd,
  output skt_pkg::stat_t                       stat,
  input  logic [1:0]                           operation,
  input  logic signed [skt_pkg::KEY_W-1:0]     key,
  input  logic [skt_pkg::PAY_PORT_W-1:0]       payload,
  output logic [1:0]                           status,
  output logic signed [skt_pkg::KEY_W-1:0]     found_key,
  output logic [skt_pkg::PAY_PORT_W-1:0]       found_payload,
  output logic                                 last
);
  import skt_pkg::*;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int STORE_W = (PAYLOAD_WIDTH < PAY_PORT_W) ? PAYLOAD_WIDTH : PAY_PORT_W;

  op_t                      req_op;
  logic signed [KEY_W-1:0]  req_key;
  logic [STORE_W-1:0]       req_pay;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         dump_left;

  logic signed [KEY_W-1:0]  cell_key  [CAPACITY];
  logic [STORE_W-1:0]       cell_pay  [CAPACITY];
  logic signed [KEY_W-1:0]  key_next  [CAPACITY];
  logic [STORE_W-1:0]       pay_next  [CAPACITY];
  logic signed [KEY_W-1:0]  prev_key  [CAPACITY];
  logic [STORE_W-1:0]       prev_pay  [CAPACITY];
  logic signed [KEY_W-1:0]  nxt_key   [CAPACITY];
  logic [STORE_W-1:0]       nxt_pay   [CAPACITY];

  logic [CAPACITY-1:0] valid, ge, gt, eq, first_eq, ins_mask, rm_mask, tail;
  logic [CAPACITY-1:0] new_here, shift_in;
  logic                full, empty, hit, at_front, at_end;
  logic signed [KEY_W-1:0] sel_key;
  logic [STORE_W-1:0]      sel_pay;

  status_t                 out_status;
  logic signed [KEY_W-1:0] out_key;
  logic [STORE_W-1:0]      out_pay;
  logic                    out_last;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // Per-cell comparators against the latched key, plus neighbor wiring.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    assign valid[gi] = (CNT_W'(gi) < count);
    assign ge[gi]    = valid[gi] && (cell_key[gi] >= req_key);
    assign gt[gi]    = valid[gi] && (cell_key[gi] > req_key);
    assign eq[gi]    = valid[gi] && (cell_key[gi] == req_key);
    assign tail[gi]  = (CNT_W'(gi + 1) == count);
    if (gi == 0) begin : g_head
      assign prev_key[gi] = req_key;
      assign prev_pay[gi] = req_pay;
    end else begin : g_body
      assign prev_key[gi] = cell_key[gi-1];
      assign prev_pay[gi] = cell_pay[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_end
      assign nxt_key[gi] = cell_key[0];
      assign nxt_pay[gi] = cell_pay[0];
    end else begin : g_mid
      assign nxt_key[gi] = cell_key[gi+1];
      assign nxt_pay[gi] = cell_pay[gi+1];
    end
  end

  // Keys are sorted, so equal keys are contiguous and the compare masks are
  // thermometer codes; a run start is found from one neighbor alone.
  assign first_eq = eq & ~(eq << 1);
  assign hit      = |eq;
  assign at_front = !valid[0] || ge[0];
  assign at_end   = !(|gt);

  always_comb begin
    if (at_front) begin
      ins_mask = '1;
    end else if (at_end) begin
      ins_mask = ~valid;
    end else begin
      ins_mask = ge | ~valid;
    end
  end

  assign new_here = ins_mask & ~(ins_mask << 1);
  assign shift_in = ins_mask & ~new_here;
  assign rm_mask  = ge | ~valid;

  always_comb begin
    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key = sel_key | (first_eq[i] ? cell_key[i] : '0);
      sel_pay = sel_pay | (first_eq[i] ? cell_pay[i] : '0);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_next[i] = cell_key[i];
      pay_next[i] = cell_pay[i];
      if (cmd.exec) begin
        case (req_op)
          OP_INSERT: begin
            if (!full && new_here[i]) begin
              key_next[i] = req_key;
              pay_next[i] = req_pay;
            end else if (!full && shift_in[i]) begin
              key_next[i] = prev_key[i];
              pay_next[i] = prev_pay[i];
            end
          end
          OP_REMOVE: begin
            if (hit && rm_mask[i]) begin
              key_next[i] = nxt_key[i];
              pay_next[i] = nxt_pay[i];
            end
          end
          default: begin
          end
        endcase
      end else if (cmd.dump_step) begin
        // Rotate the occupied part so the table is back in place after a full dump.
        key_next[i] = tail[i] ? cell_key[0] : nxt_key[i];
        pay_next[i] = tail[i] ? cell_pay[0] : nxt_pay[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_key[i] <= key_next[i];
      cell_pay[i] <= pay_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op  <= op_t'(operation);
      req_key <= key;
      req_pay <= payload[STORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dump_left <= '0;
    end else if (cmd.exec) begin
      dump_left <= count;
      if (req_op == OP_INSERT && !full) begin
        count <= count + CNT_W'(1);
      end else if (req_op == OP_REMOVE && hit) begin
        count <= count - CNT_W'(1);
      end
    end else if (cmd.dump_step) begin
      dump_left <= dump_left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_last <= 1'b1;
      out_key  <= '0;
      out_pay  <= '0;
      if (req_op == OP_INSERT) begin
        out_status <= full ? ST_FULL : ST_OK;
      end else if (empty) begin
        out_status <= ST_EMPTY;
      end else if (hit) begin
        out_status <= ST_OK;
        out_key    <= sel_key;
        out_pay    <= sel_pay;
      end else begin
        out_status <= ST_NOT_FOUND;
      end
    end else if (cmd.dump_step) begin
      out_status <= ST_OK;
      out_key    <= cell_key[0];
      out_pay    <= cell_pay[0];
      out_last   <= (dump_left == CNT_W'(1));
    end
  end

  assign stat.op        = req_op;
  assign stat.empty     = empty;
  assign stat.dump_last = (dump_left == CNT_W'(1));

  assign status        = out_status;
  assign found_key     = out_key;
  assign found_payload = PAY_PORT_W'(out_pay);
  assign last          = out_last;

endmodule

// ===== design/sorted_key_table_top.sv =====
// Sorted key table: a chain of key/payload cells kept in ascending key order.
// Requests enter on request_valid/request_ready with operation, key and payload.
// Results leave on result_valid/result_ready with status, found_key,
// found_payload and last; last marks the final result of a request.
// Insert, remove and search give one result; a dump gives one per entry, or
// one result with status empty when the table holds nothing.
// A request is captured in S_IDLE and executed in S_EXEC, when all cells
// compare against the key at once; insert and remove shift cells by one
// place. A dump then emits one result per entry, each step reading cell 0
// and rotating the chain.
// The result register decouples the two sides: a new request is taken while
// a result still waits; a stalled receiver holds execution and dump steps
// until the register frees up. Reset empties the table and drops any pending
// result; the cell contents themselves are not cleared.
// Depends on skt_pkg, skt_ctrl and skt_datapath.
module sorted_key_table_top #(
  parameter int CAPACITY      = skt_pkg::CAPACITY_DEFAULT,
  parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             request_valid,
  output logic                             request_ready,
  input  logic [1:0]                       operation,
  input  logic signed [skt_pkg::KEY_W-1:0] key,
  input  logic [skt_pkg::PAY_PORT_W-1:0]   payload,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [1:0]                       status,
  output logic signed [skt_pkg::KEY_W-1:0] found_key,
  output logic [skt_pkg::PAY_PORT_W-1:0]   found_payload,
  output logic                             last
);
  import skt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  skt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  skt_datapath #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .key           (key),
    .payload       (payload),
    .status        (status),
    .found_key     (found_key),
    .found_payload (found_payload),
    .last          (last)
  );

endmodule
